// ===== sv/prs_pkg.sv =====
// Package for the primorial residue sieve: widths, register indexes,
// reset values, sequencer states and the engine-to-top handshake struct.
// No dependencies.
`timescale 1ns / 1ps

package prs_pkg;

    localparam int unsigned MOD_BITS_DEF   = 52;
    localparam int unsigned TERM_BITS_DEF  = 32;
    localparam int unsigned CFG_BITS       = 32;
    localparam int unsigned CFG_INDEX_BITS = 1;

    localparam logic [CFG_BITS-1:0] START_RESIDUE_RESET   = 32'd2;
    localparam logic [CFG_BITS-1:0] MIN_REPORT_TERM_RESET = 32'd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_START_RESIDUE   = 1'b0,
        REG_MIN_REPORT_TERM = 1'b1
    } prs_cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_REDUCE,
        ST_MUL,
        ST_DONE
    } prs_state_t;

    typedef struct packed {
        logic valid;
        logic minus_one_hit;
        logic plus_one_hit;
    } prs_done_t;

endpackage

// ===== sv/prs_step_unit.sv =====
// Shared modular step: result = (2*acc + addend) mod modulus, for acc and
// addend below modulus. Serves both the reduction and the shift-add multiply.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module prs_step_unit #(
    parameter int unsigned MOD_BITS = 52
) (
    input  logic [MOD_BITS-1:0] acc,
    input  logic [MOD_BITS-1:0] addend,
    input  logic [MOD_BITS-1:0] modulus,
    output logic [MOD_BITS-1:0] result
);

    localparam int unsigned W = MOD_BITS + 2;

    logic [W-1:0] sum;
    logic [W-1:0] p1;
    logic [W-1:0] p2;
    logic [W-1:0] d1;
    logic [W-1:0] d2;

    // sum stays below 3*modulus, so at most 2*modulus comes off
    assign sum = {1'b0, acc, 1'b0} + W'(addend);
    assign p1  = W'(modulus);
    assign p2  = {1'b0, modulus, 1'b0};
    assign d1  = sum - p1;
    assign d2  = sum - p2;

    always_comb
    begin
        if (sum >= p2)
            result = MOD_BITS'(d2);
        else if (sum >= p1)
            result = MOD_BITS'(d1);
        else
            result = MOD_BITS'(sum);
    end

endmodule

// ===== sv/prs_engine.sv =====
// Sequencer and datapath registers of the sieve: optional base reduction
// (restoring remainder) and shift-add modular multiply on prs_step_unit.
// Depends on prs_pkg and prs_step_unit.
`timescale 1ns / 1ps

module prs_engine #(
    parameter int unsigned MOD_BITS  = 52,
    parameter int unsigned TERM_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [MOD_BITS-1:0]           modulus,
    input  logic [TERM_BITS-1:0]          term,
    input  logic                          first_term,
    input  logic [prs_pkg::CFG_BITS-1:0]  start_residue,
    input  logic [prs_pkg::CFG_BITS-1:0]  min_report_term,
    output logic                          busy,
    output prs_pkg::prs_done_t            done,
    output logic [MOD_BITS-1:0]           done_residue,
    output logic [TERM_BITS-1:0]          done_term,
    input  logic                          done_ack
);

    import prs_pkg::*;

    localparam int unsigned BASE_BITS = (MOD_BITS > CFG_BITS) ? MOD_BITS : CFG_BITS;
    localparam int unsigned CNT_BITS  = $clog2(BASE_BITS);

    prs_state_t state_reg, state_next;

    logic [MOD_BITS-1:0]  p_reg;
    logic [MOD_BITS-1:0]  acc_reg;
    logic [MOD_BITS-1:0]  a_reg;
    logic [MOD_BITS-1:0]  prod_reg;
    logic [BASE_BITS-1:0] base_reg;
    logic [TERM_BITS-1:0] term_reg;
    logic [TERM_BITS-1:0] tsh_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic                 zero_mod_reg;

    logic                 small_mod;
    logic                 base_small;
    logic                 cnt_last;
    logic                 report;
    logic [MOD_BITS-1:0]  addend;
    logic [MOD_BITS-1:0]  step_out;

    assign small_mod  = modulus < MOD_BITS'(2);
    assign base_small = base_reg < BASE_BITS'(p_reg);
    assign cnt_last   = cnt_reg == '0;
    assign report     = CFG_BITS'(term_reg) >= min_report_term;

    prs_step_unit #(
        .MOD_BITS (MOD_BITS)
    ) u_step (
        .acc     (acc_reg),
        .addend  (addend),
        .modulus (p_reg),
        .result  (step_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = small_mod ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = base_small ? ST_MUL : ST_REDUCE;
            end
            ST_REDUCE:
            begin
                if (cnt_last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy               = 1'b1;
        addend             = '0;
        done.valid         = 1'b0;
        done.minus_one_hit = 1'b0;
        done.plus_one_hit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_PREP:
            begin
                addend = '0;
            end
            ST_REDUCE:
            begin
                // shift in the next dividend bit
                addend = MOD_BITS'(base_reg[BASE_BITS-1]);
            end
            ST_MUL:
            begin
                addend = tsh_reg[TERM_BITS-1] ? a_reg : '0;
            end
            ST_DONE:
            begin
                done.valid         = 1'b1;
                done.minus_one_hit = !zero_mod_reg && report && (acc_reg == MOD_BITS'(1));
                done.plus_one_hit  = !zero_mod_reg && report &&
                                     (acc_reg == p_reg - MOD_BITS'(1));
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign done_residue = acc_reg;
    assign done_term    = term_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prod_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && small_mod)
                        prod_reg <= '0;
                end
                ST_PREP:
                begin
                    cnt_reg <= base_small ? CNT_BITS'(TERM_BITS - 1) : CNT_BITS'(BASE_BITS - 1);
                end
                ST_REDUCE:
                begin
                    cnt_reg <= cnt_last ? CNT_BITS'(TERM_BITS - 1) : cnt_reg - CNT_BITS'(1);
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg - CNT_BITS'(1);
                    if (cnt_last)
                        prod_reg <= step_out;
                end
                default:
                begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    p_reg        <= modulus;
                    term_reg     <= term;
                    tsh_reg      <= term;
                    zero_mod_reg <= small_mod;
                    acc_reg      <= '0;
                    base_reg     <= first_term ? BASE_BITS'(start_residue)
                                               : BASE_BITS'(prod_reg);
                end
            end
            ST_PREP:
            begin
                // base already below p: skip the reduction
                if (base_small)
                    a_reg <= MOD_BITS'(base_reg);
            end
            ST_REDUCE:
            begin
                base_reg <= base_reg << 1;
                if (cnt_last)
                begin
                    a_reg   <= step_out;
                    acc_reg <= '0;
                end
                else
                    acc_reg <= step_out;
            end
            ST_MUL:
            begin
                acc_reg <= step_out;
                tsh_reg <= tsh_reg << 1;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    a_acc_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE || state_reg == ST_MUL) |-> acc_reg < p_reg)
        else $error("accumulator not reduced below modulus");

    a_mult_below_p: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> a_reg < p_reg)
        else $error("multiplicand not reduced below modulus");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg != ST_IDLE)
        else $error("accepted item did not start the sequencer");

    a_small_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && zero_mod_reg) |-> (acc_reg == '0 && prod_reg == '0))
        else $error("modulus below two left a nonzero residue");

endmodule

// ===== sv/primorial_residue_sieve_top.sv =====
// Top level of the primorial residue sieve: configuration registers, item
// intake and the result register. Depends on prs_pkg and prs_engine.
`timescale 1ns / 1ps

// Keeps the running product of prime terms modulo the item's modulus p and
// reports the new residue per item, with hit flags for residue 1 (p divides
// term#-1) and residue p-1 (p divides term#+1) once term reaches
// min_report_term. first_term restarts the product from start_residue.
// The multiply takes one term bit per cycle on a single shared modular
// double-and-add step, between a setup state and a handoff state.
// When the stored base is not already below p (a new p smaller than the
// product, or start_residue >= p), a max(MOD_BITS,32)-bit restoring
// reduction runs first on the same step unit. A modulus below two goes
// straight to handoff with residue 0. item_stall is high until a result
// moves to the output register; the next item may enter while it waits.

module primorial_residue_sieve_top #(
    parameter int unsigned MOD_BITS  = prs_pkg::MOD_BITS_DEF,
    parameter int unsigned TERM_BITS = prs_pkg::TERM_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [prs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [prs_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [MOD_BITS-1:0]                modulus,
    input  logic [TERM_BITS-1:0]               term,
    input  logic                               first_term,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [MOD_BITS-1:0]                residue,
    output logic [TERM_BITS-1:0]               prime_term,
    output logic                               minus_one_hit,
    output logic                               plus_one_hit
);

    import prs_pkg::*;

    logic [CFG_BITS-1:0]  start_residue_reg;
    logic [CFG_BITS-1:0]  min_report_term_reg;

    logic                 result_valid_reg;
    logic [MOD_BITS-1:0]  residue_reg;
    logic [TERM_BITS-1:0] prime_term_reg;
    logic                 minus_one_hit_reg;
    logic                 plus_one_hit_reg;

    logic                 busy;
    logic                 start;
    logic                 load;
    prs_done_t            done;
    logic [MOD_BITS-1:0]  done_residue;
    logic [TERM_BITS-1:0] done_term;

    assign item_stall = busy;
    assign start      = item_valid && !busy;
    // take the finished item when the result register is empty or draining
    assign load       = done.valid && (!result_valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_residue_reg   <= START_RESIDUE_RESET;
            min_report_term_reg <= MIN_REPORT_TERM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_RESIDUE:   start_residue_reg   <= cfg_data;
                REG_MIN_REPORT_TERM: min_report_term_reg <= cfg_data;
                default:             start_residue_reg   <= start_residue_reg;
            endcase
        end
    end

    prs_engine #(
        .MOD_BITS  (MOD_BITS),
        .TERM_BITS (TERM_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .modulus         (modulus),
        .term            (term),
        .first_term      (first_term),
        .start_residue   (start_residue_reg),
        .min_report_term (min_report_term_reg),
        .busy            (busy),
        .done            (done),
        .done_residue    (done_residue),
        .done_term       (done_term),
        .done_ack        (load)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            residue_reg       <= done_residue;
            prime_term_reg    <= done_term;
            minus_one_hit_reg <= done.minus_one_hit;
            plus_one_hit_reg  <= done.plus_one_hit;
        end
    end

    assign result_valid  = result_valid_reg;
    assign residue       = residue_reg;
    assign prime_term    = prime_term_reg;
    assign minus_one_hit = minus_one_hit_reg;
    assign plus_one_hit  = plus_one_hit_reg;

endmodule

// ===== sim/tb_primorial_residue_sieve_top.sv =====
// Testbench for primorial_residue_sieve_top: runs of terms against
// moduli of all sizes, checked item by item against an exact mulmod predictor.
// Depends on prs_pkg and the block's RTL; nothing else.
`timescale 1ns / 1ps

module tb_primorial_residue_sieve_top;

    import prs_pkg::*;

    localparam int MW = MOD_BITS_DEF;
    localparam int TW = TERM_BITS_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned HOLDOFF_SPACING = 600;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [MW-1:0] modulus;
        logic [TW-1:0] term;
        logic          first;
        logic          drain;   // wait for every residue before offering this item
    } sieve_item_t;

    typedef struct {
        logic [MW-1:0] residue;
        logic [TW-1:0] prime_term;
        logic          minus_one_hit;
        logic          plus_one_hit;
    } sieve_result_t;

    typedef enum {
        STALL_NONE,
        STALL_COIN,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_START_RESIDUE;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [MW-1:0]       modulus = '0;
    logic [TW-1:0]       term = '0;
    logic                first_term = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [MW-1:0]       residue;
    logic [TW-1:0]       prime_term;
    logic                minus_one_hit;
    logic                plus_one_hit;

    // predictor state and register mirror
    logic [MW-1:0]       product_mod = '0;
    logic [CFG_BITS-1:0] start_cfg = START_RESIDUE_RESET;
    logic [CFG_BITS-1:0] min_cfg = MIN_REPORT_TERM_RESET;

    sieve_item_t   pending_items[$];
    sieve_result_t residues_due[$];
    sieve_item_t   next_item;
    sieve_result_t want;

    logic        item_fire = 1'b0;
    logic        result_fire = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned minus_hits = 0;
    int unsigned plus_hits = 0;
    int unsigned settings_run = 0;
    int unsigned holdoffs = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned next_holdoff = 150;
    int unsigned stall_left = 0;
    int unsigned stall_tick = 0;
    stall_mode_t stall_mode = STALL_NONE;

    primorial_residue_sieve_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .modulus       (modulus),
        .term          (term),
        .first_term    (first_term),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .residue       (residue),
        .prime_term    (prime_term),
        .minus_one_hit (minus_one_hit),
        .plus_one_hit  (plus_one_hit)
    );

    always #1 clk = ~clk;

    // Multiply one term into the running product modulo p, exactly.
    function automatic sieve_result_t sieve_step(input logic [MW-1:0] p,
                                                 input logic [TW-1:0] t,
                                                 input logic first);
        sieve_result_t r;
        logic [MW-1:0] base;
        logic [MW+TW-1:0] wide_base;
        logic [MW+TW-1:0] wide_p;
        logic [MW+TW-1:0] prod;
        logic report;
        r.prime_term = t;
        r.residue = '0;
        r.minus_one_hit = 1'b0;
        r.plus_one_hit = 1'b0;
        if (p < MW'(2))
        begin
            product_mod = '0;
        end
        else
        begin
            base = first ? MW'(start_cfg) : product_mod;
            base = base % p;
            wide_base = (MW+TW)'(base);
            wide_p = (MW+TW)'(p);
            prod = wide_base * (MW+TW)'(t);
            prod = prod % wide_p;
            r.residue = prod[MW-1:0];
            product_mod = r.residue;
            report = (t >= min_cfg);
            r.minus_one_hit = report && (r.residue == MW'(1));
            r.plus_one_hit = report && (r.residue == p - MW'(1));
        end
        return r;
    endfunction

    function automatic logic [MW-1:0] pick_modulus();
        logic [63:0] wide;
        logic [MW-1:0] p;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 19))
            0:                p = MW'($urandom_range(0, 1));
            1:                p = MW'(2);
            2:                p = '1;
            3, 4, 5, 6, 7, 8: p = MW'($urandom_range(3, 64));
            9, 10, 11:        p = MW'($urandom_range(65, 1 << 20));
            default:          p = MW'(wide >> (64 - $urandom_range(2, MW)));
        endcase
        return p;
    endfunction

    task automatic add_item(input logic [MW-1:0] p, input logic [TW-1:0] t,
                            input logic first, input logic drain);
        sieve_item_t it;
        it.modulus = p;
        it.term = t;
        it.first = first;
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    // Mostly runs that open with first_term and step the term upward; now and
    // then a new modulus mid-run, a stray restart or a wild term.
    task automatic queue_runs(input int count);
        int unsigned run_left;
        logic [MW-1:0] run_mod;
        logic [TW-1:0] run_term;
        logic [TW-1:0] t;
        logic first;
        run_left = 0;
        run_mod = MW'(7);
        run_term = TW'(2);
        for (int k = 0; k < count; k++)
        begin
            first = 1'b0;
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 24);
                run_mod = pick_modulus();
                run_term = ($urandom_range(0, 3) == 0) ? TW'($urandom)
                                                       : TW'($urandom_range(2, 40));
                first = ($urandom_range(0, 15) != 0);
            end
            else
            begin
                run_left--;
                if ($urandom_range(0, 19) == 0)
                    run_mod = pick_modulus();
                run_term = run_term + TW'($urandom_range(1, 12));
                if ($urandom_range(0, 24) == 0)
                    first = 1'b1;
            end
            t = run_term;
            if ($urandom_range(0, 15) == 0)
                t = TW'($urandom >> $urandom_range(0, 31));
            if ($urandom_range(0, 63) == 0)
                t = '1;
            add_item(run_mod, t, first, $urandom_range(0, 199) == 0);
        end
    endtask

    task automatic write_reg(input prs_cfg_reg_t idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == REG_START_RESIDUE)
            start_cfg = val;
        else
            min_cfg = val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || residues_due.size() != 0 || item_valid)
            @(negedge clk);
    endtask

    task automatic run_setting(input logic [CFG_BITS-1:0] start_val,
                               input logic [CFG_BITS-1:0] min_val, input int count);
        write_reg(REG_START_RESIDUE, start_val);
        write_reg(REG_MIN_REPORT_TERM, min_val);
        settings_run++;
        queue_runs(count);
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset registers (start 2, no minimum term)
        add_item(MW'(1000003), TW'(3), 1'b0, 1'b0);  // no run yet: product stays 0
        add_item(MW'(7), TW'(3), 1'b1, 1'b0);        // 6 = p-1
        add_item(MW'(7), TW'(4), 1'b0, 1'b0);        // 24 mod 7 = 3
        add_item(MW'(2), TW'(3), 1'b0, 1'b0);        // p shrinks to 2, both flags
        add_item(MW'(0), TW'(7), 1'b1, 1'b0);
        add_item(MW'(1), TW'(11), 1'b0, 1'b0);
        add_item(MW'(13), TW'(13), 1'b0, 1'b0);      // product cleared by tiny p
        add_item(MW'(5), TW'(3), 1'b1, 1'b0);        // 6 mod 5 = 1
        add_item('1, '1, 1'b1, 1'b0);
        add_item('1, '1, 1'b0, 1'b0);
        add_item(MW'(1000003), TW'(2), 1'b0, 1'b0);  // reduce a wide product
        add_item({1'b1, {(MW-1){1'b0}}}, {1'b1, {(TW-1){1'b0}}}, 1'b0, 1'b0);
        add_item(MW'(3), TW'(2), 1'b1, 1'b1);
        add_item(MW'(3), TW'(5), 1'b0, 1'b0);
        add_item(MW'(2), '1, 1'b1, 1'b0);
        add_item({(MW-1){1'b1}} - MW'(58), TW'(2), 1'b1, 1'b0);
        add_item(MW'(4), TW'(1), 1'b0, 1'b0);
        add_item(MW'(2), TW'(0), 1'b0, 1'b0);
        wait_idle();

        run_setting(START_RESIDUE_RESET, MIN_REPORT_TERM_RESET, 450);
        run_setting(32'd1, 32'hFFFF_FFFF, 300);
        run_setting(32'hFFFF_FFFF, 32'd0, 300);
        run_setting($urandom, $urandom_range(0, 200), 400);
        run_setting($urandom_range(1, 100), $urandom_range(0, 50), 380);

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d items checked under %0d register settings plus reset values",
                 results_seen, settings_run);
        $display("hits seen: %0d minus-one, %0d plus-one; %0d long receiver hold-offs",
                 minus_hits, plus_hits, holdoffs);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // item driver: bursts of items with random gaps, payload held while stalled
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (item_valid && !item_fire)
        begin
            // hold the offered item
        end
        else if (gap_left != 0)
        begin
            item_valid <= 1'b0;
            gap_left--;
        end
        else if (pending_items.size() == 0 ||
                 (pending_items[0].drain && residues_due.size() != 0))
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            next_item = pending_items.pop_front();
            modulus <= next_item.modulus;
            term <= next_item.term;
            first_term <= next_item.first;
            item_valid <= 1'b1;
            if (burst_left > 1)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
            end
        end
    end

    // result receiver: stall patterns that change now and then, plus long hold-offs
    always @(negedge clk)
    begin
        stall_tick++;
        if (hold_left == 0 && results_seen >= next_holdoff)
        begin
            hold_left = HOLDOFF_CYCLES;
            next_holdoff += HOLDOFF_SPACING;
            holdoffs++;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 400);
            end
            else
            begin
                stall_left--;
            end
            case (stall_mode)
                STALL_NONE:  result_stall <= 1'b0;
                STALL_COIN:  result_stall <= 1'($urandom_range(0, 1));
                STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
                default:     result_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    // monitor: predict on each accepted item, check each accepted result
    always @(posedge clk)
    begin
        item_fire = rst_n && item_valid && !item_stall;
        result_fire = rst_n && result_valid && !result_stall;
        if (result_fire)
        begin
            if (residues_due.size() == 0)
            begin
                $error("result with no item outstanding: residue %0h term %0h",
                       residue, prime_term);
                errors++;
            end
            else
            begin
                want = residues_due.pop_front();
                results_seen++;
                minus_hits += 32'(want.minus_one_hit);
                plus_hits += 32'(want.plus_one_hit);
                if (residue !== want.residue)
                begin
                    $error("residue: expected %0h, got %0h", want.residue, residue);
                    errors++;
                end
                if (prime_term !== want.prime_term)
                begin
                    $error("prime_term: expected %0h, got %0h", want.prime_term, prime_term);
                    errors++;
                end
                if (minus_one_hit !== want.minus_one_hit)
                begin
                    $error("minus_one_hit: expected %0b, got %0b",
                           want.minus_one_hit, minus_one_hit);
                    errors++;
                end
                if (plus_one_hit !== want.plus_one_hit)
                begin
                    $error("plus_one_hit: expected %0b, got %0b",
                           want.plus_one_hit, plus_one_hit);
                    errors++;
                end
            end
        end
        if (item_fire)
            residues_due.push_back(sieve_step(modulus, term, first_term));
        if (item_fire || result_fire || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, residues_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
sv/prs_pkg.sv
sv/prs_step_unit.sv
sv/prs_engine.sv
sv/primorial_residue_sieve_top.sv
sim/tb_primorial_residue_sieve_top.sv
